FILE: src/slcg_pkg.sv
package slcg_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_EMIT  = 2'd2;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    localparam int RAND_LSB  = 16;
    localparam int RAND_BITS = 15;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] seed_byte;
        logic       first_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0] random_byte;
        logic       no_seed;
    } t_out_item;

    typedef struct packed {
        logic       step;
        logic       absorb;
        logic [7:0] seed_byte;
    } t_lcg_ctl;

endpackage

FILE: src/seeded_lcg_byte_generator_core.sv
// Seeded byte generator on the ANSI C rand linear congruential generator.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command per
// transfer: clear the seed store, load and absorb a seed byte, or emit one
// random byte. Only emit produces a result, on the output channel
// (o_out_valid / i_out_ready / o_out_data); command code 3 is dropped.
//
// An emit result passes from its input transfer through the read stage (the
// registered seed-store read) and the output register to o_out_valid.
// Throughput: one command per cycle while the output is not stalled, set by
// the generator state update (32-bit constant multiply-add) and the single
// write and read port of the seed store.
//
// Reset sets the generator state to one and the seed store to empty; no
// clearing pass is run, the store is tracked by its fill count.
// When the receiver stalls, the output register holds its result and one
// further emit may still be taken into the read stage; after that
// o_in_ready drops until the output moves.
module seeded_lcg_byte_generator_core #(
    parameter int SEED_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slcg_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slcg_pkg::t_out_item o_out_data
);

    localparam int IW = $clog2(SEED_DEPTH);
    localparam int LW = $clog2(SEED_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(SEED_DEPTH);

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;

    logic          r_s1_valid;
    logic          r_s1_no_seed;
    logic [7:0]    r_s1_rand8;
    logic          r_out_valid;
    slcg_pkg::t_out_item r_out_data;

    logic          w_mv;
    logic          w_in_ready;
    logic          w_acc;
    logic          w_is_emit;
    logic          w_has_seed;
    logic          w_room;
    logic          w_restart;
    logic [IW-1:0] w_idx_base;
    logic [LW-1:0] w_idx_inc;
    logic          w_wrap;
    logic          w_we;
    logic          w_re;
    logic [7:0]    w_rdata;
    logic [slcg_pkg::RAND_BITS-1:0] w_rand15;
    slcg_pkg::t_lcg_ctl w_ctl;

    assign w_mv       = !r_out_valid || i_out_ready;
    assign w_in_ready = !r_s1_valid || w_mv;
    assign w_acc      = i_in_valid && w_in_ready;
    assign w_is_emit  = (i_in_data.command == slcg_pkg::CMD_EMIT);
    assign w_has_seed = (r_len != '0);
    assign w_room     = (r_len < DEPTH_L);

    assign w_restart  = i_in_data.first_of_buffer || (LW'(r_idx) >= r_len);
    assign w_idx_base = w_restart ? '0 : r_idx;
    assign w_idx_inc  = LW'(w_idx_base) + LW'(1);
    assign w_wrap     = (w_idx_inc >= r_len);

    always_comb begin
        n_len           = r_len;
        n_idx           = r_idx;
        w_ctl.step      = 1'b0;
        w_ctl.absorb    = 1'b0;
        w_ctl.seed_byte = i_in_data.seed_byte;
        w_we            = 1'b0;
        w_re            = 1'b0;
        if (w_acc) begin
            case (i_in_data.command)
                slcg_pkg::CMD_CLEAR: begin
                    n_len = '0;
                    n_idx = '0;
                end
                slcg_pkg::CMD_LOAD: begin
                    if (w_room) begin
                        n_len        = r_len + LW'(1);
                        w_ctl.step   = 1'b1;
                        w_ctl.absorb = 1'b1;
                        w_we         = 1'b1;
                    end
                end
                slcg_pkg::CMD_EMIT: begin
                    if (w_has_seed) begin
                        n_idx      = w_wrap ? '0 : w_idx_inc[IW-1:0];
                        w_ctl.step = 1'b1;
                        w_re       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    slcg_lcg u_lcg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_rand15 (w_rand15)
    );

    slcg_ram #(
        .WIDTH (8),
        .DEPTH (SEED_DEPTH)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[IW-1:0]),
        .i_wdata (i_in_data.seed_byte),
        .i_re    (w_re),
        .i_raddr (w_idx_base),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            r_idx <= n_idx;
            if (w_in_ready) begin
                r_s1_valid <= i_in_valid && w_is_emit;
            end
            if (w_mv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready) begin
            r_s1_no_seed <= !w_has_seed;
            r_s1_rand8   <= w_rand15[7:0];
        end
        if (w_mv) begin
            r_out_data.no_seed     <= r_s1_no_seed;
            r_out_data.random_byte <= r_s1_no_seed ? 8'd0 : (r_s1_rand8 + w_rdata);
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= DEPTH_L)
        else $error("seed length exceeds store depth");

    a_idx_in_seed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> (LW'(r_idx) < r_len))
        else $error("seed index outside stored seed");

    a_idx_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) |-> (r_idx == '0))
        else $error("seed index nonzero with empty store");

    a_stall_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are held");

    a_no_seed_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_emit && !w_has_seed) |-> ##2
        (!o_out_valid || o_out_data.no_seed || !$past(w_mv)))
        else $error("empty-store emit lost its no_seed flag");

endmodule

FILE: src/slcg_ram.sv
module slcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/slcg_lcg.sv
module slcg_lcg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  slcg_pkg::t_lcg_ctl                 i_ctl,
    output logic [slcg_pkg::RAND_BITS-1:0]     o_rand15
);

    logic [31:0] r_state;
    logic [31:0] n_state;
    logic [31:0] w_prod;
    logic [31:0] w_absorbed;

    assign w_prod   = r_state * slcg_pkg::LCG_MUL + slcg_pkg::LCG_ADD;
    assign o_rand15 = w_prod[slcg_pkg::RAND_LSB +: slcg_pkg::RAND_BITS];

    assign w_absorbed = {{(32 - slcg_pkg::RAND_BITS){1'b0}}, o_rand15}
                      + {{24{i_ctl.seed_byte[7]}}, i_ctl.seed_byte};

    always_comb begin
        n_state = i_ctl.absorb ? w_absorbed : w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 32'd1;
        end else if (i_ctl.step) begin
            r_state <= n_state;
        end
    end

endmodule
